// ===== rtl/dppc_pkg.sv =====
// Shared constants and types for the dual-channel PID position controller.
package dppc_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_LEFT_P_GAIN    = 3'd0,
      CSR_LEFT_I_GAIN    = 3'd1,
      CSR_LEFT_D_GAIN    = 3'd2,
      CSR_RIGHT_P_GAIN   = 3'd3,
      CSR_RIGHT_I_GAIN   = 3'd4,
      CSR_RIGHT_D_GAIN   = 3'd5,
      CSR_INTEGRAL_LIMIT = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int LIMIT_WIDTH     = 20;
   localparam int POWER_WIDTH     = 16;
   localparam int RSP_DATA_WIDTH  = 2 * POWER_WIDTH;

   // Reset gains, given in Q2.16 and rescaled to the configured fraction
   localparam int REF_FRACTION_BITS    = 16;
   localparam longint LEFT_P_RESET     = 26214;
   localparam longint LEFT_I_RESET     = 131;
   localparam longint LEFT_D_RESET     = 19661;
   localparam longint RIGHT_P_RESET    = 19464;
   localparam longint RIGHT_I_RESET    = 131;
   localparam longint RIGHT_D_RESET    = 15729;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 20'd1000;

   localparam logic signed [POWER_WIDTH-1:0] POWER_MAX = 16'sh7fff;
   localparam logic signed [POWER_WIDTH-1:0] POWER_MIN = 16'sh8000;

endpackage

// ===== rtl/dual_pid_position_controller.sv =====
// Top level: two-channel PID position controller, four register stages.
// Usage
//   req_*  : one control tick per item. req_tuser is the enable bit; a tick
//            with enable low is taken and dropped, gives no result and leaves
//            the error history and integrals as they are.
//   rsp_*  : one item per enabled tick, holding both drive powers.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Path: an enabled tick passes the input register, error/integral stage,
//   multiplier stage and result register before it shows on rsp_tvalid.
// Throughput: one tick per cycle while rsp_tready is high; the error/integral
//   stage updates per-channel history per tick, so ticks may arrive back to back.
// Stall: each stage has its own valid bit and moves when the stage after it
//   is empty or moving, so bubbles close up and up to four ticks are held
//   while rsp_tready is low; req_tready drops only when all stages are full.
// Reset: clears all valid bits, the error history and integrals, and loads
//   the default gains and integral limit.
// Integral: above integral_limit it is cleared, otherwise it saturates to
//   the signed SUM_WIDTH range. Powers are truncated toward zero and
//   saturated to 16 bits signed.
module dual_pid_position_controller
   import dppc_pkg::*;
#(
   parameter int POSITION_WIDTH     = 16,
   parameter int SUM_WIDTH          = 32,
   parameter int GAIN_FRACTION_BITS = 16,
   localparam int REQ_DATA_WIDTH    = ((3 * POSITION_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // tdata: target, left_position, right_position (lowest bits first)
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // tuser: enable
   input  logic                       req_tuser,
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tdata: left drive, right drive (lowest bits first)
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // configuration writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int P   = POSITION_WIDTH;
   localparam int S   = SUM_WIDTH;
   localparam int F   = GAIN_FRACTION_BITS;
   localparam int G   = F + 2;                    // gain width
   localparam int E   = P + 1;                    // error width
   localparam int D   = P + 2;                    // derivative width
   localparam int SW1 = ((S > E) ? S : E) + 1;    // raw integral width
   localparam int CW  = ((SW1 > LIMIT_WIDTH + 1) ? SW1 : LIMIT_WIDTH + 1) + 1;
   localparam int PE  = E + G + 1;                // error product
   localparam int PD  = D + G + 1;                // derivative product
   localparam int PS  = S + G + 1;                // integral product
   localparam int TW  = ((PD > PS) ? PD : PS) + 2;
   localparam int QW  = TW - F;

   localparam logic [G-1:0] LEFT_P_INIT  = G'((LEFT_P_RESET << F) >> REF_FRACTION_BITS);
   localparam logic [G-1:0] LEFT_I_INIT  = G'((LEFT_I_RESET << F) >> REF_FRACTION_BITS);
   localparam logic [G-1:0] LEFT_D_INIT  = G'((LEFT_D_RESET << F) >> REF_FRACTION_BITS);
   localparam logic [G-1:0] RIGHT_P_INIT = G'((RIGHT_P_RESET << F) >> REF_FRACTION_BITS);
   localparam logic [G-1:0] RIGHT_I_INIT = G'((RIGHT_I_RESET << F) >> REF_FRACTION_BITS);
   localparam logic [G-1:0] RIGHT_D_INIT = G'((RIGHT_D_RESET << F) >> REF_FRACTION_BITS);

   localparam logic signed [CW-1:0] SUM_MAX = CW'((64'sd1 <<< (S - 1)) - 64'sd1);
   localparam logic signed [CW-1:0] SUM_MIN = -SUM_MAX - CW'(1);
   localparam logic signed [TW-1:0] ROUND_BIAS = TW'((64'sd1 <<< F) - 64'sd1);
   localparam logic signed [QW-1:0] Q_MAX = QW'(POWER_MAX);
   localparam logic signed [QW-1:0] Q_MIN = QW'(POWER_MIN);

   // ---------------------------------------------------------------
   // configuration registers
   logic [G-1:0]           left_p_ff, left_i_ff, left_d_ff;
   logic [G-1:0]           right_p_ff, right_i_ff, right_d_ff;
   logic [LIMIT_WIDTH-1:0] limit_ff;

   assign csr_ready = 1'b1;

   // write the addressed register, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_p_ff  <= LEFT_P_INIT;
         left_i_ff  <= LEFT_I_INIT;
         left_d_ff  <= LEFT_D_INIT;
         right_p_ff <= RIGHT_P_INIT;
         right_i_ff <= RIGHT_I_INIT;
         right_d_ff <= RIGHT_D_INIT;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEFT_P_GAIN:    left_p_ff  <= csr_data[G-1:0];
            CSR_LEFT_I_GAIN:    left_i_ff  <= csr_data[G-1:0];
            CSR_LEFT_D_GAIN:    left_d_ff  <= csr_data[G-1:0];
            CSR_RIGHT_P_GAIN:   right_p_ff <= csr_data[G-1:0];
            CSR_RIGHT_I_GAIN:   right_i_ff <= csr_data[G-1:0];
            CSR_RIGHT_D_GAIN:   right_d_ff <= csr_data[G-1:0];
            CSR_INTEGRAL_LIMIT: limit_ff   <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage handshakes: a stage moves when the next one is empty or moving
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic a_ready, b_ready, c_ready, out_ready;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign c_ready    = !c_valid_ff || out_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign rsp_tvalid = rsp_valid_ff;

   // advance valid bits; a disabled tick never enters the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_ready)   a_valid_ff   <= req_tvalid && req_tuser;
         if (b_ready)   b_valid_ff   <= a_valid_ff;
         if (c_ready)   c_valid_ff   <= b_valid_ff;
         if (out_ready) rsp_valid_ff <= c_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage A: input register
   logic signed [P-1:0] a_target_ff, a_lpos_ff, a_rpos_ff;

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_target_ff <= req_tdata[P-1:0];
         a_lpos_ff   <= req_tdata[2*P-1:P];
         a_rpos_ff   <= req_tdata[3*P-1:2*P];
      end
   end

   // ---------------------------------------------------------------
   // stage B: errors, integrals and derivatives, history update
   logic signed [E-1:0] l_last_ff, r_last_ff;
   logic signed [S-1:0] l_sum_ff, r_sum_ff;
   logic signed [E-1:0] l_err_in, r_err_in;
   logic signed [S-1:0] l_sum_in, r_sum_in;
   logic signed [D-1:0] l_der_in, r_der_in;
   logic signed [E-1:0] b_lerr_ff, b_rerr_ff;
   logic signed [S-1:0] b_lsum_ff, b_rsum_ff;
   logic signed [D-1:0] b_lder_ff, b_rder_ff;
   logic                b_load;

   // add the error into the integral: clear above the limit, else saturate
   function automatic logic signed [S-1:0] next_sum(
      input logic signed [S-1:0]           sum,
      input logic signed [E-1:0]           err,
      input logic        [LIMIT_WIDTH-1:0] limit
   );
      logic signed [CW-1:0] raw;
      logic signed [CW-1:0] lim;
      raw = CW'(sum) + CW'(err);
      lim = $signed(CW'(limit));
      if (raw > lim)          next_sum = '0;
      else if (raw > SUM_MAX) next_sum = SUM_MAX[S-1:0];
      else if (raw < SUM_MIN) next_sum = SUM_MIN[S-1:0];
      else                    next_sum = raw[S-1:0];
   endfunction

   assign b_load   = a_valid_ff && b_ready;
   assign l_err_in = E'(a_target_ff) - E'(a_lpos_ff);
   assign r_err_in = E'(a_target_ff) + E'(a_rpos_ff);   // right encoder inverted
   assign l_sum_in = next_sum(l_sum_ff, l_err_in, limit_ff);
   assign r_sum_in = next_sum(r_sum_ff, r_err_in, limit_ff);
   assign l_der_in = D'(l_err_in) - D'(l_last_ff);
   assign r_der_in = D'(r_err_in) - D'(r_last_ff);

   // hold history except when an enabled tick passes through
   always_ff @(posedge clock) begin
      if (reset) begin
         l_last_ff <= '0;
         r_last_ff <= '0;
         l_sum_ff  <= '0;
         r_sum_ff  <= '0;
      end else if (b_load) begin
         l_last_ff <= l_err_in;
         r_last_ff <= r_err_in;
         l_sum_ff  <= l_sum_in;
         r_sum_ff  <= r_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_lerr_ff <= l_err_in;
         b_rerr_ff <= r_err_in;
         b_lsum_ff <= l_sum_in;
         b_rsum_ff <= r_sum_in;
         b_lder_ff <= l_der_in;
         b_rder_ff <= r_der_in;
      end
   end

   // ---------------------------------------------------------------
   // stage C: gain products
   logic signed [PE-1:0] c_lp_ff, c_rp_ff;
   logic signed [PS-1:0] c_li_ff, c_ri_ff;
   logic signed [PD-1:0] c_ld_ff, c_rd_ff;

   always_ff @(posedge clock) begin
      if (b_valid_ff && c_ready) begin
         c_lp_ff <= PE'(b_lerr_ff) * $signed(PE'({1'b0, left_p_ff}));
         c_li_ff <= PS'(b_lsum_ff) * $signed(PS'({1'b0, left_i_ff}));
         c_ld_ff <= PD'(b_lder_ff) * $signed(PD'({1'b0, left_d_ff}));
         c_rp_ff <= PE'(b_rerr_ff) * $signed(PE'({1'b0, right_p_ff}));
         c_ri_ff <= PS'(b_rsum_ff) * $signed(PS'({1'b0, right_i_ff}));
         c_rd_ff <= PD'(b_rder_ff) * $signed(PD'({1'b0, right_d_ff}));
      end
   end

   // ---------------------------------------------------------------
   // stage D: sum terms, drop the fraction toward zero, saturate
   function automatic logic signed [POWER_WIDTH-1:0] to_power(
      input logic signed [PE-1:0] prop,
      input logic signed [PS-1:0] integ,
      input logic signed [PD-1:0] deriv
   );
      logic signed [TW-1:0] total;
      logic signed [TW-1:0] biased;
      logic signed [QW-1:0] quot;
      total  = TW'(prop) + TW'(integ) + TW'(deriv);
      biased = total[TW-1] ? total + ROUND_BIAS : total;
      quot   = QW'(biased >>> F);
      if (quot > Q_MAX)      to_power = POWER_MAX;
      else if (quot < Q_MIN) to_power = POWER_MIN;
      else                   to_power = quot[POWER_WIDTH-1:0];
   endfunction

   logic signed [POWER_WIDTH-1:0] l_power_in, r_power_in;
   logic signed [POWER_WIDTH-1:0] l_power_ff, r_power_ff;

   assign l_power_in = to_power(c_lp_ff, c_li_ff, c_ld_ff);
   assign r_power_in = to_power(c_rp_ff, c_ri_ff, c_rd_ff);

   always_ff @(posedge clock) begin
      if (c_valid_ff && out_ready) begin
         l_power_ff <= l_power_in;
         r_power_ff <= r_power_in;
      end
   end

   assign rsp_tdata = {r_power_ff, l_power_ff};

   // ---------------------------------------------------------------
   // checks
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !b_load |=> $stable(l_sum_ff) && $stable(r_sum_ff)
                  && $stable(l_last_ff) && $stable(r_last_ff))
      else $error("history changed without an enabled item");

   a_hist_reset: assert property (@(posedge clock)
      $past(reset) |-> l_sum_ff == '0 && r_sum_ff == '0
                       && l_last_ff == '0 && r_last_ff == '0)
      else $error("history not cleared by reset");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(c_valid_ff))
      else $error("result appeared without an item in the multiplier stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_valid_ff && b_valid_ff && c_valid_ff && rsp_valid_ff)
      else $error("input stalled while a stage is empty");

endmodule
